// ===== rtl/lc3x_pkg.sv =====
// Shared types, opcodes and the microcode table of the LC-3 execute block.
package lc3x_pkg;

	typedef struct packed {
		logic        cmd;
		logic [15:0] load_addr;
		logic [15:0] load_data;
	} req_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic [15:0] executed_word;
		logic [2:0]  flags;
		logic        reg_written;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
		logic        mem_written;
		logic [15:0] mem_addr;
		logic [15:0] mem_data;
	} result_t;

	typedef enum logic [3:0] {
		OP_BR   = 4'd0,
		OP_ADD  = 4'd1,
		OP_LD   = 4'd2,
		OP_ST   = 4'd3,
		OP_JSR  = 4'd4,
		OP_AND  = 4'd5,
		OP_LDR  = 4'd6,
		OP_STR  = 4'd7,
		OP_RTI  = 4'd8,
		OP_NOT  = 4'd9,
		OP_LDI  = 4'd10,
		OP_STI  = 4'd11,
		OP_JMP  = 4'd12,
		OP_RES  = 4'd13,
		OP_LEA  = 4'd14,
		OP_TRAP = 4'd15
	} op_t;

	localparam logic [15:0] START_PC_RESET = 16'h3000;
	localparam logic [2:0]  FLAGS_RESET    = 3'b010;
	localparam logic [2:0]  FLAG_P         = 3'b001;
	localparam logic [2:0]  FLAG_Z         = 3'b010;
	localparam logic [2:0]  FLAG_N         = 3'b100;
	localparam logic [2:0]  LINK_REG       = 3'd7;

	// Memory address source
	typedef enum logic [2:0] {
		MA_PC        = 3'd0,
		MA_PC_OFF9   = 3'd1,
		MA_BASE_OFF6 = 3'd2,
		MA_RDATA     = 3'd3,
		MA_LOAD      = 3'd4
	} ma_sel_t;

	typedef enum logic {
		WD_LOAD = 1'b0,
		WD_B    = 1'b1
	} wd_sel_t;

	typedef enum logic {
		BS_SR2 = 1'b0,
		BS_DR  = 1'b1
	} bs_sel_t;

	typedef enum logic [2:0] {
		PC_HOLD = 3'd0,
		PC_INC  = 3'd1,
		PC_BR   = 3'd2,
		PC_BASE = 3'd3,
		PC_JSR  = 3'd4
	} pc_sel_t;

	typedef enum logic [2:0] {
		RV_ADD = 3'd0,
		RV_AND = 3'd1,
		RV_NOT = 3'd2,
		RV_MEM = 3'd3,
		RV_PC  = 3'd4,
		RV_LEA = 3'd5
	} rv_sel_t;

	typedef enum logic [1:0] {
		SEQ_NEXT     = 2'd0,
		SEQ_JUMP     = 2'd1,
		SEQ_DISPATCH = 2'd2,
		SEQ_DONE     = 2'd3
	} seq_t;

	typedef logic [4:0] upc_t;

	typedef struct packed {
		ma_sel_t ma_sel;
		logic    mem_we;
		wd_sel_t wd_sel;
		logic    ir_ld;
		logic    a_ld;
		logic    b_ld;
		bs_sel_t b_sel;
		pc_sel_t pc_sel;
		logic    rf_we;
		rv_sel_t rv_sel;
		logic    dst_link;
		logic    flags_we;
		seq_t    seq;
		upc_t    target;
	} ctrl_t;

	localparam upc_t U_LOAD   = 5'd0;
	localparam upc_t U_FETCH  = 5'd1;
	localparam upc_t U_DECODE = 5'd2;
	localparam upc_t U_ADD    = 5'd3;
	localparam upc_t U_AND    = 5'd4;
	localparam upc_t U_NOT    = 5'd5;
	localparam upc_t U_BR     = 5'd6;
	localparam upc_t U_JMP    = 5'd7;
	localparam upc_t U_JSR    = 5'd8;
	localparam upc_t U_LD0    = 5'd9;
	localparam upc_t U_WBM    = 5'd10;
	localparam upc_t U_LDI0   = 5'd11;
	localparam upc_t U_LDI1   = 5'd12;
	localparam upc_t U_LDR0   = 5'd13;
	localparam upc_t U_LEA    = 5'd14;
	localparam upc_t U_ST0    = 5'd15;
	localparam upc_t U_ST1    = 5'd16;
	localparam upc_t U_STI0   = 5'd17;
	localparam upc_t U_STI1   = 5'd18;
	localparam upc_t U_STR0   = 5'd19;
	localparam upc_t U_STR1   = 5'd20;
	localparam upc_t U_NOP    = 5'd21;

	function automatic logic [2:0] flags_of(input logic [15:0] v);
		logic [2:0] f;
		if (v == 16'h0000) begin
			f = FLAG_Z;
		end else if (v[15]) begin
			f = FLAG_N;
		end else begin
			f = FLAG_P;
		end
		return f;
	endfunction

	function automatic upc_t dispatch(input op_t op);
		upc_t u;
		case (op)
			OP_ADD:  u = U_ADD;
			OP_AND:  u = U_AND;
			OP_NOT:  u = U_NOT;
			OP_BR:   u = U_BR;
			OP_JMP:  u = U_JMP;
			OP_JSR:  u = U_JSR;
			OP_LD:   u = U_LD0;
			OP_LDI:  u = U_LDI0;
			OP_LDR:  u = U_LDR0;
			OP_LEA:  u = U_LEA;
			OP_ST:   u = U_ST0;
			OP_STI:  u = U_STI0;
			OP_STR:  u = U_STR0;
			default: u = U_NOP;
		endcase
		return u;
	endfunction

	// Microcode table: one control word per step
	function automatic ctrl_t ucode(input upc_t upc);
		ctrl_t c;
		c = '0;
		case (upc)
			U_LOAD: begin
				c.ma_sel = MA_LOAD; c.mem_we = 1'b1; c.wd_sel = WD_LOAD;
				c.seq = SEQ_DONE;
			end
			U_FETCH: begin
				c.ma_sel = MA_PC; c.seq = SEQ_NEXT;
			end
			U_DECODE: begin
				c.ir_ld = 1'b1; c.pc_sel = PC_INC; c.a_ld = 1'b1;
				c.b_ld = 1'b1; c.b_sel = BS_SR2; c.seq = SEQ_DISPATCH;
			end
			U_ADD: begin
				c.rf_we = 1'b1; c.rv_sel = RV_ADD; c.flags_we = 1'b1; c.seq = SEQ_DONE;
			end
			U_AND: begin
				c.rf_we = 1'b1; c.rv_sel = RV_AND; c.flags_we = 1'b1; c.seq = SEQ_DONE;
			end
			U_NOT: begin
				c.rf_we = 1'b1; c.rv_sel = RV_NOT; c.flags_we = 1'b1; c.seq = SEQ_DONE;
			end
			U_BR: begin
				c.pc_sel = PC_BR; c.seq = SEQ_DONE;
			end
			U_JMP: begin
				c.pc_sel = PC_BASE; c.seq = SEQ_DONE;
			end
			U_JSR: begin
				c.rf_we = 1'b1; c.rv_sel = RV_PC; c.dst_link = 1'b1;
				c.pc_sel = PC_JSR; c.seq = SEQ_DONE;
			end
			U_LD0: begin
				c.ma_sel = MA_PC_OFF9; c.seq = SEQ_NEXT;
			end
			U_WBM: begin
				c.rf_we = 1'b1; c.rv_sel = RV_MEM; c.flags_we = 1'b1; c.seq = SEQ_DONE;
			end
			U_LDI0: begin
				c.ma_sel = MA_PC_OFF9; c.seq = SEQ_NEXT;
			end
			U_LDI1: begin
				c.ma_sel = MA_RDATA; c.seq = SEQ_JUMP; c.target = U_WBM;
			end
			U_LDR0: begin
				c.ma_sel = MA_BASE_OFF6; c.seq = SEQ_JUMP; c.target = U_WBM;
			end
			U_LEA: begin
				c.rf_we = 1'b1; c.rv_sel = RV_LEA; c.flags_we = 1'b1; c.seq = SEQ_DONE;
			end
			U_ST0: begin
				c.b_ld = 1'b1; c.b_sel = BS_DR; c.seq = SEQ_NEXT;
			end
			U_ST1: begin
				c.ma_sel = MA_PC_OFF9; c.mem_we = 1'b1; c.wd_sel = WD_B; c.seq = SEQ_DONE;
			end
			U_STI0: begin
				c.ma_sel = MA_PC_OFF9; c.b_ld = 1'b1; c.b_sel = BS_DR; c.seq = SEQ_NEXT;
			end
			U_STI1: begin
				c.ma_sel = MA_RDATA; c.mem_we = 1'b1; c.wd_sel = WD_B; c.seq = SEQ_DONE;
			end
			U_STR0: begin
				c.b_ld = 1'b1; c.b_sel = BS_DR; c.seq = SEQ_NEXT;
			end
			U_STR1: begin
				c.ma_sel = MA_BASE_OFF6; c.mem_we = 1'b1; c.wd_sel = WD_B; c.seq = SEQ_DONE;
			end
			default: begin
				c.seq = SEQ_DONE;
			end
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/lc3x_useq.sv =====
// Microcode sequencer: step counter, control-word table and dispatch on the opcode.
module lc3x_useq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic             go_cmd,
	input  lc3x_pkg::op_t    opcode,
	output lc3x_pkg::ctrl_t  ctrl,
	output logic             run
);
	import lc3x_pkg::*;

	upc_t upc_q, upc_d;
	logic run_q, run_d;

	always_comb begin
		ctrl = run_q ? ucode(upc_q) : ctrl_t'('0);
	end

	always_comb begin
		upc_d = upc_q;
		run_d = run_q;
		if (go) begin
			upc_d = go_cmd ? U_FETCH : U_LOAD;
			run_d = 1'b1;
		end else if (run_q) begin
			case (ctrl.seq)
				SEQ_NEXT:     upc_d = upc_q + 5'd1;
				SEQ_JUMP:     upc_d = ctrl.target;
				SEQ_DISPATCH: upc_d = dispatch(opcode);
				SEQ_DONE:     run_d = 1'b0;
				default:      run_d = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_LOAD;
			run_q <= 1'b0;
		end else begin
			upc_q <= upc_d;
			run_q <= run_d;
		end
	end

	assign run = run_q;

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> !run_q)
		else $error("sequencer started while running");
	a_go_runs: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> run_q && (upc_q == U_FETCH || upc_q == U_LOAD))
		else $error("sequencer entry point wrong");
	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		run_q && ctrl.seq == SEQ_DONE && !go |=> !run_q)
		else $error("sequencer kept running after last step");

endmodule

// ===== rtl/lc3_instruction_execute_top.sv =====
// Top level of the LC-3 execute block: memory, register file and datapath.
//
// Usage: drive req and pulse start while busy is low; the item is taken at
// that edge and busy rises. req.cmd = 0 writes req.load_data to memory at
// req.load_addr; req.cmd = 1 fetches the word at the program counter and
// executes it. One result per item appears on result for exactly one cycle
// with done high; it cannot be held off. busy is low again in that cycle,
// so the next item may be taken at the edge that ends it.
// Each item runs through microcode steps in order: a memory load is a single
// write step; an instruction has a fetch, a decode, then for LD/LDR/LDI/ST/
// STR/STI the steps that read the single synchronous memory port or load the
// store register (LDI reads memory twice, STI does both in one step), and a
// last execute or write step. The done cycle follows the last step, and a
// new item is taken no earlier than that done cycle.
// start_pc_we writes start_pc_wdata into the program counter; write only
// while busy is low and no result is pending.
// Reset clears the registers to zero, flags to Z and the program counter to
// 0x3000; memory contents are undefined until loaded. MEM_WORDS must be a
// power of two, which the block does not check; addresses wrap modulo it.
module lc3_instruction_execute_top #(
	parameter int MEM_WORDS = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lc3x_pkg::req_t    req,
	input  logic              start_pc_we,
	input  logic [15:0]       start_pc_wdata,
	output logic              done,
	output lc3x_pkg::result_t result
);
	import lc3x_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);

	ctrl_t       ctrl;
	logic        run;
	logic        accept;
	logic        step_done;

	req_t        req_q;
	logic [15:0] mem_q [MEM_WORDS];
	logic [15:0] mem_rdata_q;
	logic [15:0] rf_q [8];
	logic [15:0] ir_q, pc_q, a_q, b_q;
	logic [2:0]  flags_q;
	result_t     result_q;
	logic        done_q;

	logic [15:0] ir_w, off9, off6, off11, imm5, pc_off9, base_off6, alu_b;
	logic [2:0]  sr1, dr, sr2, b_idx, w_idx;
	logic [15:0] mem_addr_full, mem_wdata, rval, pc_d;
	logic [AW-1:0] mem_idx;
	logic [2:0]  flags_d;

	assign accept = start && !run;
	assign busy   = run;

	lc3x_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (accept),
		.go_cmd (req.cmd),
		.opcode (op_t'(mem_rdata_q[15:12])),
		.ctrl   (ctrl),
		.run    (run)
	);

	assign step_done = run && (ctrl.seq == SEQ_DONE);

	// Decode fields straight off the memory output during the decode step
	assign ir_w  = ctrl.ir_ld ? mem_rdata_q : ir_q;
	assign sr1   = ir_w[8:6];
	assign dr    = ir_w[11:9];
	assign sr2   = ir_w[2:0];
	assign b_idx = (ctrl.b_sel == BS_DR) ? dr : sr2;
	assign w_idx = ctrl.dst_link ? LINK_REG : dr;

	assign off9  = {{7{ir_w[8]}}, ir_w[8:0]};
	assign off6  = {{10{ir_w[5]}}, ir_w[5:0]};
	assign off11 = {{5{ir_w[10]}}, ir_w[10:0]};
	assign imm5  = {{11{ir_w[4]}}, ir_w[4:0]};

	assign pc_off9   = pc_q + off9;
	assign base_off6 = a_q + off6;
	assign alu_b     = ir_w[5] ? imm5 : b_q;

	always_comb begin
		case (ctrl.ma_sel)
			MA_PC:        mem_addr_full = pc_q;
			MA_PC_OFF9:   mem_addr_full = pc_off9;
			MA_BASE_OFF6: mem_addr_full = base_off6;
			MA_RDATA:     mem_addr_full = mem_rdata_q;
			MA_LOAD:      mem_addr_full = req_q.load_addr;
			default:      mem_addr_full = pc_q;
		endcase
	end

	assign mem_idx   = mem_addr_full[AW-1:0];
	assign mem_wdata = (ctrl.wd_sel == WD_B) ? b_q : req_q.load_data;

	always_comb begin
		case (ctrl.rv_sel)
			RV_ADD:  rval = a_q + alu_b;
			RV_AND:  rval = a_q & alu_b;
			RV_NOT:  rval = ~a_q;
			RV_MEM:  rval = mem_rdata_q;
			RV_PC:   rval = pc_q;
			RV_LEA:  rval = pc_off9;
			default: rval = pc_q;
		endcase
	end

	always_comb begin
		case (ctrl.pc_sel)
			PC_HOLD: pc_d = pc_q;
			PC_INC:  pc_d = pc_q + 16'd1;
			PC_BR:   pc_d = ((flags_q & dr) != 3'b000) ? pc_off9 : pc_q;
			PC_BASE: pc_d = a_q;
			PC_JSR:  pc_d = ir_w[11] ? (pc_q + off11) : a_q;
			default: pc_d = pc_q;
		endcase
	end

	assign flags_d = (ctrl.rf_we && ctrl.flags_we) ? flags_of(rval) : flags_q;

	// Single-port memory with registered read
	always_ff @(posedge clk) begin
		if (run && ctrl.mem_we) begin
			mem_q[mem_idx] <= mem_wdata;
		end
		mem_rdata_q <= mem_q[mem_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				rf_q[i] <= 16'h0000;
			end
		end else if (run && ctrl.rf_we) begin
			rf_q[w_idx] <= rval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= START_PC_RESET;
			flags_q <= FLAGS_RESET;
			done_q  <= 1'b0;
		end else begin
			done_q <= step_done;
			if (start_pc_we) begin
				pc_q <= start_pc_wdata;
			end else if (run) begin
				pc_q    <= pc_d;
				flags_q <= flags_d;
			end
		end
	end

	// Datapath registers without reset
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (ctrl.ir_ld) begin
			ir_q <= mem_rdata_q;
		end
		if (ctrl.a_ld) begin
			a_q <= rf_q[sr1];
		end
		if (ctrl.b_ld) begin
			b_q <= rf_q[b_idx];
		end
		if (step_done) begin
			result_q.next_pc       <= pc_d;
			result_q.executed_word <= req_q.cmd ? ir_w : 16'h0000;
			result_q.flags         <= flags_d;
			result_q.reg_written   <= ctrl.rf_we;
			result_q.reg_index     <= ctrl.rf_we ? w_idx : 3'd0;
			result_q.reg_value     <= ctrl.rf_we ? rval : 16'h0000;
			result_q.mem_written   <= ctrl.mem_we;
			result_q.mem_addr      <= ctrl.mem_we ? 16'(mem_idx) : 16'h0000;
			result_q.mem_data      <= ctrl.mem_we ? mem_wdata : 16'h0000;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("item taken but block not busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.reg_written && result.mem_written))
		else $error("item wrote both a register and memory");
	a_flags_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot(result.flags))
		else $error("condition flags not one-hot");
	a_done_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(run))
		else $error("result without a running item");

endmodule
